### design/bmp_pkg.sv
// Package for the block max pooling design: payload structs, field widths,
// register indexes and the width of the maxima store epoch tag.
// No dependencies; imported by block_max_pooling_top.
package bmp_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int VAL_W       = SAMPLE_W - 1;
    localparam int OUT_COL_W   = 16;
    localparam int OUT_ROW_W   = 12;
    localparam int EPOCH_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 2'd3;

    localparam logic [8:0]  BLOCK_ROWS_RST = 9'd2;
    localparam logic [8:0]  BLOCK_COLS_RST = 9'd2;
    localparam logic [12:0] NUM_ROWS_RST   = 13'd4096;
    localparam logic [15:0] NUM_COLS_RST   = 16'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       start_req;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0]     pooled;
        logic [OUT_COL_W-1:0] out_col;
        logic [OUT_ROW_W-1:0] out_row;
        logic                 matrix_done;
    } t_out_item;

endpackage

### design/block_max_pooling_top.sv
// Block max pooling top level: counters, maxima RAM with read-modify-write
// pipeline, epoch-tagged clearing and a two-entry output buffer.
// Depends on bmp_pkg.

// Non-overlapping 2D max pooling of a matrix streamed column by column, each
// column top to bottom, one element per transfer. The block takes one element
// per clock cycle when not stalled; a result passes the second stage and the
// output buffer after the element that closes its block. Running maxima live in
// a MAX_ROWS-entry RAM read at acceptance and written back in the next cycle,
// with forwarding between back-to-back elements of the same row block. Each
// RAM word carries an epoch tag, so a start flag clears all maxima at once.
// The RAM is swept clean after reset and again whenever a start flag would wrap
// the epoch tag (the 256th start flag after reset, then every 255th); no element
// is taken during a sweep, while configuration writes are taken as ever.
module block_max_pooling_top #(
    parameter int MAX_ROWS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bmp_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bmp_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [bmp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bmp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bmp_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int MW = EPOCH_W + VAL_W;
    localparam logic [RW-1:0] LAST_ADDR = RW'(MAX_ROWS - 1);

    // configuration
    logic [8:0]  r_block_rows;
    logic [8:0]  r_block_cols;
    logic [12:0] r_num_rows;
    logic [15:0] r_num_cols;

    // position counters
    logic [15:0]   r_col_count, n_col_count;
    logic [RW-1:0] r_row_count, n_row_count;
    logic [7:0]    r_col_in_blk, n_col_in_blk;
    logic [7:0]    r_row_in_blk, n_row_in_blk;
    logic [RW-1:0] r_row_blk, n_row_blk;
    logic [15:0]   r_col_blk, n_col_blk;

    // maxima RAM and clearing sweep
    logic [MW-1:0]      r_mem [MAX_ROWS];
    logic [MW-1:0]      r_rd_data;
    logic [EPOCH_W-1:0] r_epoch;
    logic               r_clr;
    logic [RW-1:0]      r_clr_addr;

    // second stage
    logic                 r_s1_v;
    logic [RW-1:0]        r_s1_addr;
    logic [VAL_W-1:0]     r_s1_val;
    logic                 r_s1_emit;
    logic                 r_s1_zero;
    logic                 r_s1_fwd;
    logic [VAL_W-1:0]     r_s1_fwd_val;
    logic [OUT_COL_W-1:0] r_s1_col;
    logic                 r_s1_done;

    // output buffer
    t_out_item  r_ob [2];
    logic       r_ob_head;
    logic [1:0] r_ob_cnt;

    // effective limits, all minus one
    logic [7:0]    br_m1, bc_m1;
    logic [RW-1:0] nr_m1;
    logic [15:0]   nc_m1;

    // first stage
    logic          start;
    logic [15:0]   cur_col_count;
    logic [RW-1:0] cur_row_count;
    logic [7:0]    cur_col_in_blk;
    logic [7:0]    cur_row_in_blk;
    logic [RW-1:0] cur_row_blk;
    logic [15:0]   cur_col_blk;
    logic          last_row, last_col, row_end, col_end, emit;
    logic [VAL_W-1:0] s0_val;
    logic          accept;
    logic          clr_req;
    logic          fwd;

    // second stage logic
    logic [EPOCH_W-1:0] rd_tag;
    logic [VAL_W-1:0]   rd_val;
    logic [VAL_W-1:0]   base;
    logic [VAL_W-1:0]   new_max;
    logic [VAL_W-1:0]   wr_val;
    logic               push;
    logic               pop;
    logic [1:0]         occ;
    t_out_item          s1_item;

    always_comb begin
        if (r_block_rows == 9'd0) begin
            br_m1 = 8'd0;
        end else if (r_block_rows > 9'd256) begin
            br_m1 = 8'd255;
        end else begin
            br_m1 = 8'(r_block_rows - 9'd1);
        end
        if (r_block_cols == 9'd0) begin
            bc_m1 = 8'd0;
        end else if (r_block_cols > 9'd256) begin
            bc_m1 = 8'd255;
        end else begin
            bc_m1 = 8'(r_block_cols - 9'd1);
        end
        if (r_num_rows == 13'd0) begin
            nr_m1 = '0;
        end else if (32'(r_num_rows) > 32'(MAX_ROWS)) begin
            nr_m1 = LAST_ADDR;
        end else begin
            nr_m1 = RW'(32'(r_num_rows) - 32'd1);
        end
        if (r_num_cols == 16'd0) begin
            nc_m1 = 16'd0;
        end else begin
            nc_m1 = r_num_cols - 16'd1;
        end
    end

    always_comb begin
        start          = i_in_data.start_req;
        cur_col_count  = start ? '0 : r_col_count;
        cur_row_count  = start ? '0 : r_row_count;
        cur_col_in_blk = start ? '0 : r_col_in_blk;
        cur_row_in_blk = start ? '0 : r_row_in_blk;
        cur_row_blk    = start ? '0 : r_row_blk;
        cur_col_blk    = start ? '0 : r_col_blk;

        // negative samples count as zero
        s0_val = i_in_data.sample[SAMPLE_W-1] ? '0 : i_in_data.sample[VAL_W-1:0];

        last_row = cur_row_count >= nr_m1;
        last_col = cur_col_count >= nc_m1;
        row_end  = last_row || (cur_row_in_blk >= br_m1);
        col_end  = last_col || (cur_col_in_blk >= bc_m1);
        emit     = row_end && col_end;

        n_col_count  = cur_col_count;
        n_row_count  = cur_row_count;
        n_col_in_blk = cur_col_in_blk;
        n_row_in_blk = cur_row_in_blk;
        n_row_blk    = cur_row_blk;
        n_col_blk    = cur_col_blk;
        if (last_row) begin
            n_row_count  = '0;
            n_row_in_blk = '0;
            n_row_blk    = '0;
            if (last_col) begin
                n_col_count  = '0;
                n_col_in_blk = '0;
                n_col_blk    = '0;
            end else begin
                n_col_count = cur_col_count + 16'd1;
                if (col_end) begin
                    n_col_in_blk = '0;
                    n_col_blk    = cur_col_blk + 16'd1;
                end else begin
                    n_col_in_blk = cur_col_in_blk + 8'd1;
                end
            end
        end else begin
            n_row_count = cur_row_count + RW'(1);
            if (row_end) begin
                n_row_in_blk = '0;
                n_row_blk    = cur_row_blk + RW'(1);
            end else begin
                n_row_in_blk = cur_row_in_blk + 8'd1;
            end
        end
    end

    always_comb begin
        rd_tag  = r_rd_data[MW-1 -: EPOCH_W];
        rd_val  = r_rd_data[VAL_W-1:0];
        if (r_s1_zero) begin
            base = '0;
        end else if (r_s1_fwd) begin
            base = r_s1_fwd_val;
        end else if (rd_tag == r_epoch) begin
            base = rd_val;
        end else begin
            base = '0;
        end
        new_max = (r_s1_val > base) ? r_s1_val : base;
        wr_val  = r_s1_emit ? '0 : new_max;

        s1_item.pooled      = new_max;
        s1_item.out_col     = r_s1_col;
        s1_item.out_row     = OUT_ROW_W'(r_s1_addr);
        s1_item.matrix_done = r_s1_done;
    end

    assign push    = r_s1_v && r_s1_emit;
    assign pop     = o_out_valid && !i_out_stall;
    assign occ     = r_ob_cnt + 2'(push) - 2'(pop);
    assign clr_req = i_in_valid && start && (r_epoch == '1) && !r_clr;
    assign o_in_stall = r_clr || clr_req || (occ > 2'd1);
    assign accept  = i_in_valid && !o_in_stall;
    // the item in the second stage writes back this cycle; its value bypasses the RAM
    assign fwd     = r_s1_v && (r_s1_addr == cur_row_blk) && !start;

    assign o_out_valid = (r_ob_cnt != 2'd0);
    assign o_out_data  = r_ob[r_ob_head];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_rows <= BLOCK_ROWS_RST;
            r_block_cols <= BLOCK_COLS_RST;
            r_num_rows   <= NUM_ROWS_RST;
            r_num_cols   <= NUM_COLS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_ROWS: r_block_rows <= 9'(i_cfg_data);
                REG_BLOCK_COLS: r_block_cols <= 9'(i_cfg_data);
                REG_NUM_ROWS:   r_num_rows   <= 13'(i_cfg_data);
                REG_NUM_COLS:   r_num_cols   <= 16'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // counters, epoch and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count  <= '0;
            r_row_count  <= '0;
            r_col_in_blk <= '0;
            r_row_in_blk <= '0;
            r_row_blk    <= '0;
            r_col_blk    <= '0;
            r_epoch      <= '0;
            r_clr        <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            if (accept) begin
                r_col_count  <= n_col_count;
                r_row_count  <= n_row_count;
                r_col_in_blk <= n_col_in_blk;
                r_row_in_blk <= n_row_in_blk;
                r_row_blk    <= n_row_blk;
                r_col_blk    <= n_col_blk;
                if (start) begin
                    r_epoch <= r_epoch + EPOCH_W'(1);
                end
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + RW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr   <= 1'b0;
                    r_epoch <= '0;
                end
            end else if (clr_req && !r_s1_v) begin
                // wait for the last write-back to land, then sweep
                r_clr      <= 1'b1;
                r_clr_addr <= '0;
            end
        end
    end

    // maxima RAM
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_s1_v) begin
            r_mem[r_s1_addr] <= {r_epoch, wr_val};
        end
        if (accept) begin
            r_rd_data <= r_mem[cur_row_blk];
        end
    end

    // second stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr    <= cur_row_blk;
            r_s1_val     <= s0_val;
            r_s1_emit    <= emit;
            r_s1_zero    <= start;
            r_s1_fwd     <= fwd;
            r_s1_fwd_val <= wr_val;
            r_s1_col     <= cur_col_blk;
            r_s1_done    <= last_row && last_col;
        end
    end

    // output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_head <= 1'b0;
            r_ob_cnt  <= '0;
        end else begin
            r_ob_cnt <= occ;
            if (pop) begin
                r_ob_head <= ~r_ob_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ob[r_ob_head ^ r_ob_cnt[0]] <= s1_item;
        end
    end

endmodule

### tb/sv/tb_block_max_pooling_top.sv
// Self-checking testbench for block_max_pooling_top: streams matrices with random stalls
// and compares each pooled block maximum against an in-bench model of the pooling.
// Depends on bmp_pkg and block_max_pooling_top.
module tb_block_max_pooling_top;
    import bmp_pkg::*;

    localparam int MAX_ROWS    = 4096;
    localparam int IDLE_PCT    = 17;
    localparam int GAP_PCT     = 10;
    localparam int HOLD_LEN    = 300;
    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE      = 8;
    localparam int ITEM_TARGET = 1250;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // register copies as the block holds them
    logic [8:0]  rows_per_blk = BLOCK_ROWS_RST;
    logic [8:0]  cols_per_blk = BLOCK_COLS_RST;
    logic [12:0] rows_per_col = NUM_ROWS_RST;
    logic [15:0] cols_per_mat = NUM_COLS_RST;

    // pooling state
    logic [VAL_W-1:0] blk_max [MAX_ROWS];
    int unsigned      col_cnt, row_cnt, col_in_blk, row_in_blk, row_blk, col_blk;

    t_out_item pooled_due [$];
    int        mismatches = 0;
    int        sent = 0;
    int        quiet_cycles = 0;
    bit        idle_on = 1'b1;
    int        hold_req = 0;

    block_max_pooling_top #(
        .MAX_ROWS(MAX_ROWS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic clear_pool();
        foreach (blk_max[r]) blk_max[r] = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        col_in_blk = 0;
        row_in_blk = 0;
        row_blk    = 0;
        col_blk    = 0;
    endtask

    function automatic int unsigned clamp_blk(logic [8:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return 32'(v);
    endfunction

    task automatic pool_element(t_in_item it);
        int unsigned      br, bc, nr, nc;
        logic [VAL_W-1:0] val;
        bit               last_row, last_col, row_end, col_end;
        t_out_item        res;
        br = clamp_blk(rows_per_blk);
        bc = clamp_blk(cols_per_blk);
        nr = 32'(rows_per_col);
        nc = 32'(cols_per_mat);
        if (nr == 0) nr = 1;
        if (nr > MAX_ROWS) nr = MAX_ROWS;
        if (nc == 0) nc = 1;
        if (it.start_req) clear_pool();
        // negative samples pool as zero
        val = it.sample[SAMPLE_W-1] ? '0 : it.sample[VAL_W-1:0];
        last_row = row_cnt >= nr - 1;
        last_col = col_cnt >= nc - 1;
        row_end  = last_row || row_in_blk >= br - 1;
        col_end  = last_col || col_in_blk >= bc - 1;
        if (row_blk < MAX_ROWS) begin
            if (val > blk_max[row_blk]) blk_max[row_blk] = val;
            if (row_end && col_end) begin
                res.pooled      = blk_max[row_blk];
                res.out_col     = OUT_COL_W'(col_blk);
                res.out_row     = OUT_ROW_W'(row_blk);
                res.matrix_done = last_row && last_col;
                pooled_due = {pooled_due, res};
                blk_max[row_blk] = '0;
            end
        end
        if (last_row) begin
            row_cnt    = 0;
            row_in_blk = 0;
            row_blk    = 0;
            if (last_col) begin
                col_cnt    = 0;
                col_in_blk = 0;
                col_blk    = 0;
            end else begin
                col_cnt++;
                if (col_end) begin
                    col_in_blk = 0;
                    col_blk++;
                end else begin
                    col_in_blk++;
                end
            end
        end else begin
            row_cnt++;
            if (row_end) begin
                row_in_blk = 0;
                row_blk++;
            end else begin
                row_in_blk++;
            end
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) pool_element(i_in_data);
    end

    always @(posedge i_clk) begin : check_pooled
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pooled_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out_data);
            end else begin
                want = pooled_due.pop_front();
                check_field("pooled", 32'(want.pooled), 32'(o_out_data.pooled));
                check_field("out_col", 32'(want.out_col), 32'(o_out_data.out_col));
                check_field("out_row", 32'(want.out_row), 32'(o_out_data.out_row));
                check_field("matrix_done", 32'(want.matrix_done),
                            32'(o_out_data.matrix_done));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin : out_stall_gen
        int hold_seen;
        int hold_left;
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(logic signed [SAMPLE_W-1:0] smp, bit start);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(99) < GAP_PCT) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{sample: smp, start_req: start};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    // drop valid, wait for every pooled result, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pooled_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_BLOCK_ROWS: rows_per_blk = data[8:0];
            REG_BLOCK_COLS: cols_per_blk = data[8:0];
            REG_NUM_ROWS:   rows_per_col = data[12:0];
            REG_NUM_COLS:   cols_per_mat = data[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] br, logic [15:0] bc, logic [15:0] nr,
                            logic [15:0] nc);
        cfg_write(REG_BLOCK_ROWS, br);
        cfg_write(REG_BLOCK_COLS, bc);
        cfg_write(REG_NUM_ROWS, nr);
        cfg_write(REG_NUM_COLS, nc);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_block_size();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'd256;
            2:       return 16'($urandom_range(257, 65535));
            3:       return 16'($urandom_range(5, 256));
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 255));
            3, 4:    return {1'b1, 15'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        // 3x3 matrix in 2x2 blocks: partial blocks at the bottom and right edge
        set_regs(16'd2, 16'd2, 16'd3, 16'd3);
        send_item(16'h7fff, 1'b1);
        send_item(16'h8000, 1'b0);
        send_item(16'hffff, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h0100, 1'b0);
        send_item(16'hfffb, 1'b0);
        send_item(16'h4000, 1'b0);
        send_item(16'h7ffe, 1'b0);
        // next matrix begins without a start flag
        send_item(16'h1234, 1'b0);
        send_item(16'h8001, 1'b0);
        // start flag in mid-matrix
        send_item(16'h0042, 1'b1);
        send_item(16'h0fff, 1'b0);
        drain();
        // row counter now beyond the shrunk column height
        set_regs(16'd2, 16'd2, 16'd2, 16'd3);
        send_item(16'h0010, 1'b0);
        send_item(16'h2000, 1'b0);
        drain();
        // zero block sizes and counts act as one, oversize block as 256
        set_regs(16'd0, 16'hffff, 16'd0, 16'd0);
        send_item(16'h7fff, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h0080, 1'b0);
        drain();
        set_regs(16'd256, 16'd1, 16'hffff, 16'd65535);
        send_item(16'h0123, 1'b1);
        send_item(16'h7fff, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h0001, 1'b0);
        drain();
    endtask

    // hold the output off while the sender keeps going, so the input stalls
    task automatic test_backpressure();
        set_regs(16'd1, 16'd1, 16'd5, 16'd20);
        idle_on = 1'b0;
        hold_req++;
        for (int k = 0; k < 80; k++) send_item(pick_sample(), k == 0);
        drain();
        idle_on = 1'b1;
    endtask

    // many start flags, enough to wrap the maxima epoch tag
    task automatic test_epoch_wrap();
        set_regs(16'd2, 16'd1, 16'd2, 16'd1);
        for (int k = 0; k < 600; k++) send_item(pick_sample(), 1'($urandom_range(1)));
        drain();
    endtask

    task automatic test_random_matrices();
        int          len;
        logic [15:0] nr, nc;
        while (sent < ITEM_TARGET) begin
            case ($urandom_range(9))
                0:       nr = 16'd0;
                1:       nr = 16'd4096;
                2:       nr = 16'($urandom_range(4097, 65535));
                3:       nr = 16'($urandom_range(13, 300));
                default: nr = 16'($urandom_range(1, 12));
            endcase
            case ($urandom_range(9))
                0:       nc = 16'd0;
                1:       nc = 16'd65535;
                2:       nc = 16'($urandom_range(9, 1000));
                default: nc = 16'($urandom_range(1, 8));
            endcase
            set_regs(pick_block_size(), pick_block_size(), nr, nc);
            len = $urandom_range(20, 60);
            for (int k = 0; k < len; k++)
                send_item(pick_sample(),
                          (k == 0) ? ($urandom_range(9) < 7) : ($urandom_range(49) == 0));
            drain();
        end
    endtask

    initial begin
        clear_pool();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_epoch_wrap();
        test_random_matrices();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
design/bmp_pkg.sv
design/block_max_pooling_top.sv
tb/sv/tb_block_max_pooling_top.sv
